FILE: rtl/ppfp_pkg.sv
package ppfp_pkg;

	// Configuration register indexes.
	localparam logic REG_QUERY_X = 1'b0;
	localparam logic REG_QUERY_Y = 1'b1;

	localparam int SEG_INDEX_BITS_DEF = 16;

	// Datapath widths.
	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int MPL_W   = 36;
	localparam int ACC_W   = 74;
	localparam int DIV_W   = 68;
	localparam int SQ_IN_W  = 72;
	localparam int SQ_OUT_W = 36;
	localparam int SQ_REM_W = 40;

	// Magnitude of a signed operand for the serial multiplier.
	function automatic logic [MPL_W-1:0] mag36(input logic signed [MPL_W-1:0] x);
		logic [MPL_W-1:0] r;
		r = x[MPL_W-1] ? MPL_W'(-x) : MPL_W'(x);
		return r;
	endfunction

endpackage

FILE: rtl/ppfp_isqrt.sv
module ppfp_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ppfp_pkg::SQ_IN_W-1:0]   radicand,
	output logic                           done,
	output logic [ppfp_pkg::SQ_OUT_W-1:0]  root
);
	import ppfp_pkg::*;

	logic [SQ_IN_W-1:0]  n_q;
	logic [SQ_REM_W-1:0] rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [5:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SQ_REM_W-1:0] rem_next;
	logic [SQ_REM_W-1:0] trial;

	// One result bit per cycle: bring down two radicand bits and try the next root bit.
	assign rem_next = {rem_q[SQ_REM_W-3:0], n_q[SQ_IN_W-1:SQ_IN_W-2]};
	assign trial    = SQ_REM_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 6'(SQ_OUT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(SQ_OUT_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// Remainder and root shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[SQ_IN_W-3:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[SQ_OUT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[SQ_OUT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/point_polyline_frenet_projection_top.sv
// A vertex that opens a polyline starts no segment; a segment runs nine bit-serial
// multiplies (load, 36 bits, store), a 32-bit restoring divide, two square roots and one
// output step, all in one shared sequencer. Rejected segments end after the fourth
// multiply.
// The next vertex is taken only once the sequencer is idle.
// Reset: arst_n is asynchronous, active low, and clears the query point, the previous vertex,
// the segment count and all handshake state.
module point_polyline_frenet_projection_top #(
	parameter int SEG_INDEX_BITS = ppfp_pkg::SEG_INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // base_s[31:0], vertex_x[63:32], vertex_y[95:64]
	input  logic        s_tuser,   // first_vertex
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // seg_index[15:0], long_s[47:16], lat_d[80:48], zeros
);
	import ppfp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_POST = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam logic [3:0] OP_WXVX = 4'd0;
	localparam logic [3:0] OP_WYVY = 4'd1;
	localparam logic [3:0] OP_VXVX = 4'd2;
	localparam logic [3:0] OP_VYVY = 4'd3;
	localparam logic [3:0] OP_TLEN = 4'd4;
	localparam logic [3:0] OP_TVX  = 4'd5;
	localparam logic [3:0] OP_TVY  = 4'd6;
	localparam logic [3:0] OP_DXDX = 4'd7;
	localparam logic [3:0] OP_DYDY = 4'd8;

	logic [2:0] state_q;
	logic [3:0] op_q;

	logic signed [COORD_W-1:0] query_x_q, query_y_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic [COORD_W-1:0]        prev_base_q, seg_base_q;
	logic                      have_prev_q;
	logic [SEG_INDEX_BITS-1:0] seg_count_q, seg_idx_q;

	logic signed [DIFF_W-1:0] vx_q, vy_q, wx_q, wy_q;
	logic signed [ACC_W-1:0]  acc_q, c1_q, c2_q;
	logic [ACC_W-1:0]         mcd_q;
	logic [MPL_W-1:0]         mpl_q;
	logic                     neg_q;
	logic [5:0]               mcnt_q;

	logic [DIV_W-1:0]    r_q;
	logic [31:0]         t_q;
	logic [4:0]          dcnt_q;
	logic [DIV_W-1:0]    r_shift;

	logic [SQ_OUT_W-1:0] len_q;
	logic [33:0]         soff_q, offx_q, offy_q;
	logic                sq_sel_q;

	logic                 sq_start;
	logic [SQ_IN_W-1:0]   sq_in;
	logic                 sq_done;
	logic [SQ_OUT_W-1:0]  sq_root;

	logic [MPL_W-1:0]        mul_a, mul_b;
	logic                    mul_neg, mul_clear;
	logic signed [MPL_W-1:0] dx, dy;
	logic signed [MPL_W-1:0] vx_e, vy_e, wx_e, wy_e;
	logic [COORD_W-1:0]      in_base;
	logic signed [COORD_W-1:0] in_x, in_y;
	logic [34:0]             long_sum;
	logic [31:0]             seg_wide;

	logic        m_valid_q;
	logic [15:0] out_seg_q;
	logic [31:0] out_long_q;
	logic [32:0] out_lat_q;

	assign in_base = s_tdata[31:0];
	assign in_x    = s_tdata[63:32];
	assign in_y    = s_tdata[95:64];

	assign vx_e = MPL_W'(vx_q);
	assign vy_e = MPL_W'(vy_q);
	assign wx_e = MPL_W'(wx_q);
	assign wy_e = MPL_W'(wy_q);

	// Lateral offset: w minus the projection, offsets truncated toward zero.
	assign dx = wx_e - (vx_q[DIFF_W-1] ? -MPL_W'($signed({1'b0, offx_q})) :
		MPL_W'($signed({1'b0, offx_q})));
	assign dy = wy_e - (vy_q[DIFF_W-1] ? -MPL_W'($signed({1'b0, offy_q})) :
		MPL_W'($signed({1'b0, offy_q})));

	// Operands of the shared serial multiplier for each step.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_neg   = 1'b0;
		mul_clear = 1'b1;
		unique case (op_q)
			OP_WXVX: begin
				mul_a = mag36(wx_e); mul_b = mag36(vx_e);
				mul_neg = wx_q[DIFF_W-1] ^ vx_q[DIFF_W-1];
			end
			OP_WYVY: begin
				mul_a = mag36(wy_e); mul_b = mag36(vy_e);
				mul_neg = wy_q[DIFF_W-1] ^ vy_q[DIFF_W-1];
				mul_clear = 1'b0;
			end
			OP_VXVX: begin
				mul_a = mag36(vx_e); mul_b = mag36(vx_e);
			end
			OP_VYVY: begin
				mul_a = mag36(vy_e); mul_b = mag36(vy_e);
				mul_clear = 1'b0;
			end
			OP_TLEN: begin
				mul_a = MPL_W'(t_q); mul_b = len_q;
			end
			OP_TVX: begin
				mul_a = MPL_W'(t_q); mul_b = mag36(vx_e);
			end
			OP_TVY: begin
				mul_a = MPL_W'(t_q); mul_b = mag36(vy_e);
			end
			OP_DXDX: begin
				mul_a = mag36(dx); mul_b = mag36(dx);
			end
			OP_DYDY: begin
				mul_a = mag36(dy); mul_b = mag36(dy);
				mul_clear = 1'b0;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign r_shift  = {r_q[DIV_W-2:0], 1'b0};
	assign long_sum = 35'(prev_base_q) + 35'(soff_q);
	assign seg_wide = 32'(seg_idx_q);
	assign sq_in    = sq_sel_q ? SQ_IN_W'(acc_q) : SQ_IN_W'(c2_q);

	assign s_tready = (state_q == ST_IDLE);

	// Query point registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUERY_X: query_x_q <= cfg_data;
				REG_QUERY_Y: query_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and polyline state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_WXVX;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_base_q <= '0;
			seg_base_q  <= '0;
			have_prev_q <= 1'b0;
			seg_count_q <= '0;
			m_valid_q   <= 1'b0;
			sq_start    <= 1'b0;
		end else begin
			sq_start <= (state_q == ST_POST && op_q == OP_DYDY) ||
				(state_q == ST_DIV && dcnt_q == 5'd31);
			if (m_valid_q && m_tready && state_q != ST_OUT)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						prev_x_q    <= in_x;
						prev_y_q    <= in_y;
						seg_base_q  <= in_base;
						have_prev_q <= 1'b1;
						if (s_tuser || !have_prev_q) begin
							seg_count_q <= '0;
						end else begin
							seg_count_q <= seg_count_q + 1'b1;
							state_q     <= ST_LOAD;
							op_q        <= OP_WXVX;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mcnt_q == 6'(MPL_W - 1))
						state_q <= ST_POST;
				end
				ST_POST: begin
					unique case (op_q)
						OP_VYVY: begin
							if (c1_q > 0 && c1_q < acc_q)
								state_q <= ST_DIV;
							else
								state_q <= ST_IDLE;
						end
						OP_DYDY: begin
							state_q <= ST_SQRT;
						end
						default: begin
							op_q    <= op_q + 4'd1;
							state_q <= ST_LOAD;
						end
					endcase
				end
				ST_DIV: begin
					if (dcnt_q == 5'd31)
						state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_done) begin
						if (sq_sel_q) begin
							state_q <= ST_OUT;
						end else begin
							op_q    <= OP_TLEN;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// The previous base moves once the current segment is finished with it.
			if (state_q == ST_IDLE && s_tvalid && (s_tuser || !have_prev_q))
				prev_base_q <= in_base;
			else if ((state_q == ST_POST && op_q == OP_VYVY && !(c1_q > 0 && c1_q < acc_q))
					|| (state_q == ST_OUT && (!m_valid_q || m_tready)))
				prev_base_q <= seg_base_q;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			vx_q      <= DIFF_W'(in_x) - DIFF_W'(prev_x_q);
			vy_q      <= DIFF_W'(in_y) - DIFF_W'(prev_y_q);
			wx_q      <= DIFF_W'(query_x_q) - DIFF_W'(prev_x_q);
			wy_q      <= DIFF_W'(query_y_q) - DIFF_W'(prev_y_q);
			seg_idx_q <= seg_count_q;
		end
		// Load one multiply, clearing the sum at the start of a dot product.
		if (state_q == ST_LOAD) begin
			mcd_q  <= ACC_W'(mul_a);
			mpl_q  <= mul_b;
			neg_q  <= mul_neg;
			mcnt_q <= '0;
			if (mul_clear)
				acc_q <= '0;
		end
		// One multiplier bit per cycle.
		if (state_q == ST_MUL) begin
			if (mpl_q[0])
				acc_q <= neg_q ? acc_q - $signed(mcd_q) : acc_q + $signed(mcd_q);
			mcd_q  <= {mcd_q[ACC_W-2:0], 1'b0};
			mpl_q  <= {1'b0, mpl_q[MPL_W-1:1]};
			mcnt_q <= mcnt_q + 6'd1;
		end
		if (state_q == ST_POST) begin
			unique case (op_q)
				OP_WYVY: c1_q <= acc_q;
				OP_VYVY: begin
					c2_q   <= acc_q;
					r_q    <= DIV_W'(c1_q);
					t_q    <= '0;
					dcnt_q <= '0;
				end
				OP_TLEN: soff_q <= acc_q[65:32];
				OP_TVX:  offx_q <= acc_q[65:32];
				OP_TVY:  offy_q <= acc_q[65:32];
				OP_DYDY: sq_sel_q <= 1'b1;
				default: ;
			endcase
		end
		// Restoring divide, one quotient bit per cycle.
		if (state_q == ST_DIV) begin
			dcnt_q   <= dcnt_q + 5'd1;
			sq_sel_q <= 1'b0;
			if (r_shift >= DIV_W'(c2_q)) begin
				r_q <= r_shift - DIV_W'(c2_q);
				t_q <= {t_q[30:0], 1'b1};
			end else begin
				r_q <= r_shift;
				t_q <= {t_q[30:0], 1'b0};
			end
		end
		if (state_q == ST_SQRT && sq_done && !sq_sel_q)
			len_q <= sq_root;
		// Result word with saturation.
		if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
			out_seg_q  <= seg_wide[15:0];
			out_long_q <= (long_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : long_sum[31:0];
			out_lat_q  <= (sq_root[SQ_OUT_W-1:33] != '0) ? {33{1'b1}} : sq_root[32:0];
		end
	end

	ppfp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, out_lat_q, out_long_q, out_seg_q};

`ifndef SYNTHESIS
	// New vertices are only taken while the sequencer is idle.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE) else $error("vertex taken while busy");

	// The root unit only finishes while the sequencer waits on it.
	a_sqrt_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQRT) else $error("root finished out of sequence");

	// The divide remainder stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> r_q < DIV_W'(c2_q)) else $error("divide remainder too large");

	// A result is only raised from the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
`endif

endmodule
